/* rtl/core/pva_pkg.sv */
// ----------------------------------------------------------------------------
// pva_pkg: shared types and constants of the view angle block
// Field widths, datapath widths, register indexes and the CORDIC angle set.
// ----------------------------------------------------------------------------
package pva_pkg;

   localparam int CORDIC_STAGES   = 24;
   localparam int PIXEL_FRAC_BITS = 4;

   localparam int COORD_W = 17;
   localparam int FOCAL_W = 18;
   localparam int SIZE_W  = 14;
   localparam int K_W     = 26;
   localparam int ANGLE_W = 24;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 26;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_K_HORIZONTAL = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_K_VERTICAL   = 2'd3;
   localparam logic [SIZE_W-1:0] FRAME_WIDTH_RESET  = 14'd1920;
   localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RESET = 14'd1080;

   // Offset magnitude |2c - size| in pixel fraction units.
   localparam int SPAN_W    = SIZE_W + PIXEL_FRAC_BITS;
   localparam int MAG_W     = (COORD_W + 1 > SPAN_W) ? COORD_W + 1 : SPAN_W;
   localparam int NUM_SHIFT = 16 - PIXEL_FRAC_BITS;
   localparam int PROD_W    = MAG_W + K_W;
   localparam int NUM_W     = PROD_W + NUM_SHIFT;
   localparam int DEN_W     = SIZE_W + FOCAL_W;

   // Tangent in Q24, saturated at 2^44.
   localparam int TAN_FRAC    = 24;
   localparam int TAN_SAT_BIT = 44;
   localparam int QUO_W       = TAN_SAT_BIT + 1;
   localparam int DIV_TOP_W   = NUM_W - QUO_W;
   localparam int DIV_N       = QUO_W + 1;

   // CORDIC datapath: x, y and the Q40 angle accumulator.
   localparam int XY_W   = TAN_SAT_BIT + 3;
   localparam int Z_W    = 43;
   localparam int ZMAG_W = Z_W - 1;
   localparam int CR_N   = CORDIC_STAGES + 1;

   // Radians Q40 to degrees Q16.
   localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
   localparam int PI38_W = 40;
   localparam logic [PI38_W-1:0] PI38 = PI38_W'(PI_Q60 >> 22);
   localparam int DEG_HALF_TURN = 180;
   localparam int DEG_SHIFT = 14;
   localparam int DEGN_W    = 64;
   localparam int DEG_Q_W   = 23;
   localparam logic [ANGLE_W-1:0] DEG_LIMIT = 24'd5898240;

   // Division by pi38 as a multiply by floor(2^63 / pi38) on the upper
   // dividend bits; the estimate is at most one below the true quotient.
   localparam int RECIP_W       = 24;
   localparam int RECIP_SHIFT   = 63;
   localparam int DEG_NH_LSB    = 24;
   localparam int DEG_NH_W      = 39;
   localparam int DEG_EST_SHIFT = RECIP_SHIFT - DEG_NH_LSB;
   localparam logic [RECIP_W-1:0] PI38_RECIP =
      RECIP_W'(64'h8000000000000000 / 64'(PI38));

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [MAG_W-1:0]   mag_x;
      logic               neg_x;
      logic               zero_x;
      logic [MAG_W-1:0]   mag_y;
      logic               neg_y;
      logic               zero_y;
      logic [FOCAL_W-1:0] focal;
   } pva_item_type;

   typedef logic [CORDIC_STAGES-1:0][Z_W-1:0] atan_table_type;

   function automatic logic [63:0] pow_term(input int i, input int d);
      if (i * d <= 60) begin
         pow_term = 64'd1 << (60 - i * d);
      end else begin
         pow_term = 64'd0;
      end
   endfunction

   // atan(2^-i) in Q40 radians from the arctangent series, terms truncated in Q60.
   function automatic logic [Z_W-1:0] stage_angle(input int i);
      logic [63:0] s;
      if (i == 0) begin
         s = PI_Q60 >> 2;
      end else begin
         s = pow_term(i, 1) - pow_term(i, 3) / 3 + pow_term(i, 5) / 5
           - pow_term(i, 7) / 7 + pow_term(i, 9) / 9 - pow_term(i, 11) / 11
           + pow_term(i, 13) / 13 - pow_term(i, 15) / 15 + pow_term(i, 17) / 17
           - pow_term(i, 19) / 19 + pow_term(i, 21) / 21 - pow_term(i, 23) / 23
           + pow_term(i, 25) / 25 - pow_term(i, 27) / 27 + pow_term(i, 29) / 29
           - pow_term(i, 31) / 31 + pow_term(i, 33) / 33 - pow_term(i, 35) / 35
           + pow_term(i, 37) / 37 - pow_term(i, 39) / 39 + pow_term(i, 41) / 41
           - pow_term(i, 43) / 43 + pow_term(i, 45) / 45 - pow_term(i, 47) / 47
           + pow_term(i, 49) / 49 - pow_term(i, 51) / 51 + pow_term(i, 53) / 53
           - pow_term(i, 55) / 55 + pow_term(i, 57) / 57 - pow_term(i, 59) / 59;
      end
      stage_angle = Z_W'((s + (64'd1 << 19)) >> 20);
   endfunction

   function automatic atan_table_type build_atan_table();
      atan_table_type t;
      for (int i = 0; i < CORDIC_STAGES; i++) begin
         t[i] = stage_angle(i);
      end
      build_atan_table = t;
   endfunction

   localparam atan_table_type ATAN_TABLE = build_atan_table();

endpackage

/* rtl/core/pva_front.sv */
// ----------------------------------------------------------------------------
// pva_front: input stage of the view angle block
// Accepts request beats and classifies each axis: offset sign, magnitude and
// whether the angle is forced to zero.
// ----------------------------------------------------------------------------
module pva_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [pva_pkg::COORD_W-1:0]   req_center_x,
   input  logic [pva_pkg::COORD_W-1:0]   req_center_y,
   input  logic [pva_pkg::FOCAL_W-1:0]   req_focal_length,
   input  logic [pva_pkg::SIZE_W-1:0]    frame_width,
   input  logic [pva_pkg::SIZE_W-1:0]    frame_height,
   output logic                          item_valid,
   output pva_pkg::pva_item_type         item,
   input  logic                          item_full
);
   import pva_pkg::*;

   logic         valid_ff;
   pva_item_type item_ff;
   pva_item_type item_in;

   always_comb begin
      logic [MAG_W-1:0] twice_x, span_x, twice_y, span_y;
      twice_x = MAG_W'({req_center_x, 1'b0});
      span_x  = MAG_W'(frame_width) << PIXEL_FRAC_BITS;
      twice_y = MAG_W'({req_center_y, 1'b0});
      span_y  = MAG_W'(frame_height) << PIXEL_FRAC_BITS;
      item_in.neg_x  = twice_x < span_x;
      item_in.mag_x  = item_in.neg_x ? span_x - twice_x : twice_x - span_x;
      item_in.zero_x = (req_focal_length == '0) || (frame_width == '0);
      item_in.neg_y  = twice_y < span_y;
      item_in.mag_y  = item_in.neg_y ? span_y - twice_y : twice_y - span_y;
      item_in.zero_y = (req_focal_length == '0) || (frame_height == '0);
      item_in.focal  = req_focal_length;
   end

   // The held beat leaves only when the queue has room.
   assign req_stall = valid_ff & item_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!req_stall) begin
         valid_ff <= req_valid;
      end
      if (!req_stall && req_valid) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

/* rtl/core/pva_fifo.sv */
// ----------------------------------------------------------------------------
// pva_fifo: short queue between front and back
// Holds classified beats so that either side can stall on its own.
// ----------------------------------------------------------------------------
module pva_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  pva_pkg::pva_item_type push_item,
   output logic                  full,
   input  logic                  pop,
   output logic                  empty,
   output pva_pkg::pva_item_type head
);
   import pva_pkg::*;

   pva_item_type      entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W-1:0] wr_ptr_in, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full  = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign empty = count_ff == '0;
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      priority if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_in;
         if (pop)  rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue occupancy beyond its depth");

   assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == QCNT_W'($past(count_ff) + 1'b1))
      else $error("queue lost a pushed beat");

endmodule

/* rtl/core/pva_angle.sv */
// ----------------------------------------------------------------------------
// pva_angle: one axis of the back end
// Multiplies out the tangent fraction, divides one quotient bit per stage,
// runs a pipelined vectoring CORDIC and converts radians to signed degrees.
// ----------------------------------------------------------------------------
module pva_angle (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  logic [pva_pkg::MAG_W-1:0]     in_mag,
   input  logic                          in_neg,
   input  logic                          in_zero,
   input  logic [pva_pkg::FOCAL_W-1:0]   in_focal,
   input  logic [pva_pkg::SIZE_W-1:0]    frame_size,
   input  logic [pva_pkg::K_W-1:0]       lens_k,
   output logic                          out_valid,
   output logic [pva_pkg::ANGLE_W-1:0]   out_angle
);
   import pva_pkg::*;

   // Product stage.
   logic              p0_valid_ff, p0_neg_ff, p0_zero_ff;
   logic [NUM_W-1:0]  p0_num_ff;
   logic [DEN_W-1:0]  p0_den_ff;
   logic [PROD_W-1:0] prod;

   // Tangent divider.
   logic             dv_valid_ff [DIV_N];
   logic             dv_valid_in [DIV_N];
   logic [DEN_W-1:0] dv_rem_ff   [DIV_N];
   logic [DEN_W-1:0] dv_rem_in   [DIV_N];
   logic [QUO_W-1:0] dv_low_ff   [DIV_N];
   logic [QUO_W-1:0] dv_low_in   [DIV_N];
   logic [QUO_W-1:0] dv_quo_ff   [DIV_N];
   logic [QUO_W-1:0] dv_quo_in   [DIV_N];
   logic [DEN_W-1:0] dv_den_ff   [DIV_N];
   logic [DEN_W-1:0] dv_den_in   [DIV_N];
   logic             dv_sat_ff   [DIV_N];
   logic             dv_sat_in   [DIV_N];
   logic             dv_neg_ff   [DIV_N];
   logic             dv_neg_in   [DIV_N];
   logic             dv_zero_ff  [DIV_N];
   logic             dv_zero_in  [DIV_N];
   logic [DEN_W:0]   dv_trial    [DIV_N];
   logic             dv_ge       [DIV_N];
   logic [DIV_TOP_W-1:0] num_top;

   // CORDIC.
   logic                   cr_valid_ff [CR_N];
   logic                   cr_valid_in [CR_N];
   logic signed [XY_W-1:0] cr_x_ff     [CR_N];
   logic signed [XY_W-1:0] cr_x_in     [CR_N];
   logic signed [XY_W-1:0] cr_y_ff     [CR_N];
   logic signed [XY_W-1:0] cr_y_in     [CR_N];
   logic signed [Z_W-1:0]  cr_z_ff     [CR_N];
   logic signed [Z_W-1:0]  cr_z_in     [CR_N];
   logic                   cr_neg_ff   [CR_N];
   logic                   cr_neg_in   [CR_N];
   logic                   cr_zero_ff  [CR_N];
   logic                   cr_zero_in  [CR_N];
   logic signed [XY_W-1:0] cr_dx       [CR_N];
   logic signed [XY_W-1:0] cr_dy       [CR_N];
   logic [QUO_W-1:0]       tan_q;

   // Degree scaling and division by pi.
   logic              dm_valid_ff, dm_neg_ff, dm_zero_ff;
   logic [DEGN_W-1:0] dm_num_ff;
   logic [ZMAG_W-1:0] z_clamped;
   logic [ZMAG_W+7:0] z_deg;

   logic                          de_valid_ff, de_neg_ff, de_zero_ff, de_sat_ff;
   logic [DEGN_W-2:0]             de_num_ff;
   logic [DEG_Q_W-1:0]            de_quo_ff;
   logic [DEGN_W-DEG_Q_W-1:0]     deg_top;
   logic [DEG_NH_W+RECIP_W-1:0]   deg_est;

   logic                          dp_valid_ff, dp_neg_ff, dp_zero_ff, dp_sat_ff;
   logic [DEGN_W-2:0]             dp_num_ff, dp_prod_ff;
   logic [DEG_Q_W-1:0]            dp_quo_ff;

   logic                          dc_valid_ff, dc_neg_ff, dc_zero_ff, dc_sat_ff;
   logic [DEG_Q_W-1:0]            dc_quo_ff, dc_quo_in;
   logic [DEGN_W-2:0]             deg_rem;

   // Output register.
   logic               out_valid_ff;
   logic [ANGLE_W-1:0] out_angle_ff, out_angle_in;
   logic [ANGLE_W-1:0] deg_mag;

   assign prod = PROD_W'(in_mag) * PROD_W'(lens_k);

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_valid_ff <= 1'b0;
      end else if (adv) begin
         p0_valid_ff <= in_valid;
      end
      if (adv) begin
         p0_num_ff  <= NUM_W'(prod) << NUM_SHIFT;
         p0_den_ff  <= DEN_W'(frame_size) * DEN_W'(in_focal);
         p0_neg_ff  <= in_neg;
         p0_zero_ff <= in_zero;
      end
   end

   // A quotient of 2^45 or more shows up as a high part no smaller than the
   // divisor; the remaining 45 bits come one per stage.
   always_comb begin
      num_top        = p0_num_ff[NUM_W-1:QUO_W];
      dv_valid_in[0] = p0_valid_ff;
      dv_rem_in[0]   = DEN_W'(num_top);
      dv_low_in[0]   = p0_num_ff[QUO_W-1:0];
      dv_quo_in[0]   = '0;
      dv_den_in[0]   = p0_den_ff;
      dv_sat_in[0]   = DEN_W'(num_top) >= p0_den_ff;
      dv_neg_in[0]   = p0_neg_ff;
      dv_zero_in[0]  = p0_zero_ff;
      dv_trial[0]    = '0;
      dv_ge[0]       = 1'b0;
      for (int s = 1; s < DIV_N; s++) begin
         dv_trial[s]    = {dv_rem_ff[s-1], dv_low_ff[s-1][QUO_W-s]};
         dv_ge[s]       = dv_trial[s] >= {1'b0, dv_den_ff[s-1]};
         dv_rem_in[s]   = dv_ge[s] ? DEN_W'(dv_trial[s] - {1'b0, dv_den_ff[s-1]})
                                   : DEN_W'(dv_trial[s]);
         dv_quo_in[s]   = {dv_quo_ff[s-1][QUO_W-2:0], dv_ge[s]};
         dv_valid_in[s] = dv_valid_ff[s-1];
         dv_low_in[s]   = dv_low_ff[s-1];
         dv_den_in[s]   = dv_den_ff[s-1];
         dv_sat_in[s]   = dv_sat_ff[s-1];
         dv_neg_in[s]   = dv_neg_ff[s-1];
         dv_zero_in[s]  = dv_zero_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < DIV_N; s++) begin
         if (reset) begin
            dv_valid_ff[s] <= 1'b0;
         end else if (adv) begin
            dv_valid_ff[s] <= dv_valid_in[s];
         end
         if (adv) begin
            dv_rem_ff[s]  <= dv_rem_in[s];
            dv_low_ff[s]  <= dv_low_in[s];
            dv_quo_ff[s]  <= dv_quo_in[s];
            dv_den_ff[s]  <= dv_den_in[s];
            dv_sat_ff[s]  <= dv_sat_in[s];
            dv_neg_ff[s]  <= dv_neg_in[s];
            dv_zero_ff[s] <= dv_zero_in[s];
         end
      end
   end

   // The CORDIC starts from x = 1.0 and y = the saturated tangent.
   always_comb begin
      if (dv_sat_ff[DIV_N-1] ||
          dv_quo_ff[DIV_N-1] > (QUO_W'(1) << TAN_SAT_BIT)) begin
         tan_q = QUO_W'(1) << TAN_SAT_BIT;
      end else begin
         tan_q = dv_quo_ff[DIV_N-1];
      end
      cr_valid_in[0] = dv_valid_ff[DIV_N-1];
      cr_x_in[0]     = XY_W'(1) << TAN_FRAC;
      cr_y_in[0]     = XY_W'(tan_q);
      cr_z_in[0]     = '0;
      cr_neg_in[0]   = dv_neg_ff[DIV_N-1];
      cr_zero_in[0]  = dv_zero_ff[DIV_N-1] || (tan_q == '0);
      cr_dx[0]       = '0;
      cr_dy[0]       = '0;
      for (int s = 1; s < CR_N; s++) begin
         cr_dx[s] = cr_x_ff[s-1] >>> (s - 1);
         cr_dy[s] = cr_y_ff[s-1] >>> (s - 1);
         if (!cr_y_ff[s-1][XY_W-1]) begin
            cr_x_in[s] = cr_x_ff[s-1] + cr_dy[s];
            cr_y_in[s] = cr_y_ff[s-1] - cr_dx[s];
            cr_z_in[s] = cr_z_ff[s-1] + $signed(ATAN_TABLE[s-1]);
         end else begin
            cr_x_in[s] = cr_x_ff[s-1] - cr_dy[s];
            cr_y_in[s] = cr_y_ff[s-1] + cr_dx[s];
            cr_z_in[s] = cr_z_ff[s-1] - $signed(ATAN_TABLE[s-1]);
         end
         cr_valid_in[s] = cr_valid_ff[s-1];
         cr_neg_in[s]   = cr_neg_ff[s-1];
         cr_zero_in[s]  = cr_zero_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < CR_N; s++) begin
         if (reset) begin
            cr_valid_ff[s] <= 1'b0;
         end else if (adv) begin
            cr_valid_ff[s] <= cr_valid_in[s];
         end
         if (adv) begin
            cr_x_ff[s]    <= cr_x_in[s];
            cr_y_ff[s]    <= cr_y_in[s];
            cr_z_ff[s]    <= cr_z_in[s];
            cr_neg_ff[s]  <= cr_neg_in[s];
            cr_zero_ff[s] <= cr_zero_in[s];
         end
      end
   end

   // A negative accumulated angle counts as zero before scaling to degrees.
   assign z_clamped = cr_z_ff[CR_N-1][Z_W-1] ? '0 : cr_z_ff[CR_N-1][ZMAG_W-1:0];
   assign z_deg     = (ZMAG_W+8)'(z_clamped) * (ZMAG_W+8)'(DEG_HALF_TURN);

   always_ff @(posedge clock) begin
      if (reset) begin
         dm_valid_ff <= 1'b0;
      end else if (adv) begin
         dm_valid_ff <= cr_valid_ff[CR_N-1];
      end
      if (adv) begin
         dm_num_ff  <= (DEGN_W'(z_deg) << DEG_SHIFT) + DEGN_W'(PI38 >> 1);
         dm_neg_ff  <= cr_neg_ff[CR_N-1];
         dm_zero_ff <= cr_zero_ff[CR_N-1];
      end
   end

   // Division by pi in Q38; anything at or past 2^23 is beyond the clamp.
   // Below that the reciprocal estimate falls short by at most one, which
   // the back multiply and a single compare put right.
   assign deg_top = dm_num_ff[DEGN_W-1:DEG_Q_W];
   assign deg_est = (DEG_NH_W+RECIP_W)'(dm_num_ff[DEG_NH_LSB+DEG_NH_W-1:DEG_NH_LSB])
                  * (DEG_NH_W+RECIP_W)'(PI38_RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         de_valid_ff <= 1'b0;
         dp_valid_ff <= 1'b0;
         dc_valid_ff <= 1'b0;
      end else if (adv) begin
         de_valid_ff <= dm_valid_ff;
         dp_valid_ff <= de_valid_ff;
         dc_valid_ff <= dp_valid_ff;
      end
      if (adv) begin
         de_num_ff  <= dm_num_ff[DEGN_W-2:0];
         de_quo_ff  <= DEG_Q_W'(deg_est >> DEG_EST_SHIFT);
         de_sat_ff  <= deg_top >= (DEGN_W-DEG_Q_W)'(PI38);
         de_neg_ff  <= dm_neg_ff;
         de_zero_ff <= dm_zero_ff;

         dp_num_ff  <= de_num_ff;
         dp_prod_ff <= (DEGN_W-1)'(de_quo_ff) * (DEGN_W-1)'(PI38);
         dp_quo_ff  <= de_quo_ff;
         dp_sat_ff  <= de_sat_ff;
         dp_neg_ff  <= de_neg_ff;
         dp_zero_ff <= de_zero_ff;

         dc_quo_ff  <= dc_quo_in;
         dc_sat_ff  <= dp_sat_ff;
         dc_neg_ff  <= dp_neg_ff;
         dc_zero_ff <= dp_zero_ff;
      end
   end

   assign deg_rem   = dp_num_ff - dp_prod_ff;
   assign dc_quo_in = (deg_rem >= (DEGN_W-1)'(PI38)) ? dp_quo_ff + 1'b1 : dp_quo_ff;

   always_comb begin
      if (dc_sat_ff || ANGLE_W'(dc_quo_ff) > DEG_LIMIT) begin
         deg_mag = DEG_LIMIT;
      end else begin
         deg_mag = ANGLE_W'(dc_quo_ff);
      end
      if (dc_zero_ff) begin
         out_angle_in = '0;
      end else if (dc_neg_ff) begin
         out_angle_in = ~deg_mag + 1'b1;
      end else begin
         out_angle_in = deg_mag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= dc_valid_ff;
      end
      if (adv) begin
         out_angle_ff <= out_angle_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_angle = out_angle_ff;

endmodule

/* rtl/core/pixel_offset_to_view_angles.sv */
// ----------------------------------------------------------------------------
// pixel_offset_to_view_angles: pinhole lens yaw and pitch of a target
// Usage:
//   Request beats on req_* carry a target center (pixels, 4 fraction bits)
//   and the current focal length (mm, Q8). Each accepted beat yields exactly
//   one response beat on rsp_* with yaw and pitch in degrees, Q16, signed.
//   Frame size and lens constants are written through csr_write, csr_index
//   and csr_data only while no beat is in flight; the user must ensure this,
//   the block does not. Throughput is one beat per cycle while not stalled.
//   A beat passes the front register, a queue slot, the product stage, 46
//   tangent divider stages (a saturation check, then one quotient bit each),
//   25 CORDIC stages, degree scaling, three stages dividing by pi (reciprocal
//   estimate, back multiply, one correction step) and the output register.
//   While rsp_stall and rsp_valid are high the whole back end holds; the
//   four-entry queue keeps taking beats until it fills, then req_stall rises.
//   Synchronous reset empties the pipeline and queue and loads the register
//   defaults: 1920 by 1080 frame and zero lens constants.
// ----------------------------------------------------------------------------
module pixel_offset_to_view_angles (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [pva_pkg::COORD_W-1:0]         req_center_x,
   input  logic [pva_pkg::COORD_W-1:0]         req_center_y,
   input  logic [pva_pkg::FOCAL_W-1:0]         req_focal_length,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [pva_pkg::ANGLE_W-1:0]  rsp_yaw_offset,
   output logic signed [pva_pkg::ANGLE_W-1:0]  rsp_pitch_offset,
   input  logic                                csr_write,
   input  logic [pva_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [pva_pkg::CSR_DATA_W-1:0]      csr_data
);
   import pva_pkg::*;

   logic [SIZE_W-1:0] frame_width_ff, frame_height_ff;
   logic [K_W-1:0]    k_horizontal_ff, k_vertical_ff;

   logic         item_valid, item_full, q_empty, q_push, q_pop, adv;
   pva_item_type item, q_head;
   logic         x_valid, y_valid;
   logic [ANGLE_W-1:0] x_angle, y_angle;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
         k_horizontal_ff <= '0;
         k_vertical_ff   <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_data[SIZE_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_data[SIZE_W-1:0];
            CSR_K_HORIZONTAL: k_horizontal_ff <= csr_data[K_W-1:0];
            CSR_K_VERTICAL:   k_vertical_ff   <= csr_data[K_W-1:0];
         endcase
      end
   end

   pva_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_center_x     (req_center_x),
      .req_center_y     (req_center_y),
      .req_focal_length (req_focal_length),
      .frame_width      (frame_width_ff),
      .frame_height     (frame_height_ff),
      .item_valid       (item_valid),
      .item             (item),
      .item_full        (item_full)
   );

   assign q_push = item_valid & ~item_full;
   // The back end moves unless a finished beat sits stalled at the output.
   assign adv    = ~(rsp_valid & rsp_stall);
   assign q_pop  = ~q_empty & adv;

   pva_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (item),
      .full      (item_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   pva_angle u_yaw (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_valid   (~q_empty),
      .in_mag     (q_head.mag_x),
      .in_neg     (q_head.neg_x),
      .in_zero    (q_head.zero_x),
      .in_focal   (q_head.focal),
      .frame_size (frame_width_ff),
      .lens_k     (k_horizontal_ff),
      .out_valid  (x_valid),
      .out_angle  (x_angle)
   );

   pva_angle u_pitch (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_valid   (~q_empty),
      .in_mag     (q_head.mag_y),
      .in_neg     (q_head.neg_y),
      .in_zero    (q_head.zero_y),
      .in_focal   (q_head.focal),
      .frame_size (frame_height_ff),
      .lens_k     (k_vertical_ff),
      .out_valid  (y_valid),
      .out_angle  (y_angle)
   );

   assign rsp_valid        = x_valid;
   assign rsp_yaw_offset   = x_angle;
   assign rsp_pitch_offset = y_angle;

   assert property (@(posedge clock) disable iff (reset) x_valid == y_valid)
      else $error("yaw and pitch pipelines out of step");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_yaw_offset <= $signed(DEG_LIMIT)
                 && rsp_yaw_offset >= -$signed(DEG_LIMIT)
                 && rsp_pitch_offset <= $signed(DEG_LIMIT)
                 && rsp_pitch_offset >= -$signed(DEG_LIMIT))
      else $error("angle beyond ninety degrees");

endmodule

/* tb/sv/pixel_offset_to_view_angles_tb.sv */
// ----------------------------------------------------------------------------
// pixel_offset_to_view_angles_tb: self-checking bench of the view angle block
// Drives target centers and focal lengths in random bursts under several
// frame and lens settings. It predicts yaw and pitch with its own integer
// divider and CORDIC, and checks every response beat in order while the
// response side stalls on a changing pattern.
// ----------------------------------------------------------------------------
module pixel_offset_to_view_angles_tb;
   import pva_pkg::*;

   typedef struct {
      logic [COORD_W-1:0] cx;
      logic [COORD_W-1:0] cy;
      logic [FOCAL_W-1:0] focal;
   } target_type;

   typedef struct {
      logic [ANGLE_W-1:0] yaw;
      logic [ANGLE_W-1:0] pitch;
   } angles_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [COORD_W-1:0] req_center_x = '0;
   logic [COORD_W-1:0] req_center_y = '0;
   logic [FOCAL_W-1:0] req_focal_length = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [ANGLE_W-1:0] rsp_yaw_offset;
   logic signed [ANGLE_W-1:0] rsp_pitch_offset;
   logic csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // Register copies used by the predictor.
   longint unsigned width_reg = 1920;
   longint unsigned height_reg = 1080;
   longint unsigned kh_reg = 0;
   longint unsigned kv_reg = 0;

   longint unsigned atan_q40 [CORDIC_STAGES];
   target_type pending_targets [$];
   angles_type expected_angles [$];
   int errors = 0;
   int burst_left = 0;
   int gap_left = 0;
   int stall_mode = 0;
   int stall_count = 0;
   int idle_cycles = 0;

   pixel_offset_to_view_angles DUT (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // atan(2^-i) in Q40 radians: alternating series, terms truncated in Q60.
   function automatic longint unsigned arctan_pow2(int i);
      longint unsigned acc;
      longint unsigned pi_q60;
      int d;
      pi_q60 = PI_Q60;
      if (i == 0) begin
         return ((pi_q60 >> 2) + (64'd1 << 19)) >> 20;
      end
      acc = 0;
      for (int n = 0; n < 31; n++) begin
         d = 2 * n + 1;
         if (i * d > 60) break;
         if (n % 2 == 1) acc -= (64'd1 << (60 - i * d)) / d;
         else acc += (64'd1 << (60 - i * d)) / d;
      end
      return (acc + (64'd1 << 19)) >> 20;
   endfunction

   function automatic logic [ANGLE_W-1:0] view_angle(longint unsigned c,
         longint unsigned size, longint unsigned k, longint unsigned f);
      longint unsigned twice, span, mag, quo, deg, pi38;
      longint x, y, z, dx, dy;
      logic neg;
      if (f == 0 || size == 0) return '0;
      twice = c << 1;
      span = size << PIXEL_FRAC_BITS;
      neg = twice < span;
      mag = neg ? span - twice : twice - span;
      quo = ((mag * k) << (16 - PIXEL_FRAC_BITS)) / (size * f);
      if (quo > (64'd1 << 44)) quo = 64'd1 << 44;
      if (quo == 0) return '0;
      x = 64'sd1 << 24;
      y = longint'(quo);
      z = 0;
      for (int i = 0; i < CORDIC_STAGES; i++) begin
         dx = x >>> i;
         dy = y >>> i;
         if (y >= 0) begin
            x += dy;
            y -= dx;
            z += longint'(atan_q40[i]);
         end else begin
            x -= dy;
            y += dx;
            z -= longint'(atan_q40[i]);
         end
      end
      if (z < 0) z = 0;
      pi38 = 64'h3243F6A8885A308D >> 22;
      deg = (((longint'(z) * 180) << 14) + (pi38 >> 1)) / pi38;
      if (deg > 5898240) deg = 5898240;
      return neg ? ANGLE_W'(-deg) : ANGLE_W'(deg);
   endfunction

   // Request side: bursts of random length separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_angles.push_back('{
               yaw: view_angle(req_center_x, width_reg, kh_reg, req_focal_length),
               pitch: view_angle(req_center_y, height_reg, kv_reg, req_focal_length)});
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_targets.size() > 0) begin
               target_type t;
               t = pending_targets.pop_front();
               req_center_x <= t.cx;
               req_center_y <= t.cy;
               req_focal_length <= t.focal;
               req_valid <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 40);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response side: the stall pattern changes every so often.
   always @(posedge clock) begin
      stall_count++;
      if (stall_count % 97 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 2) == 0);
         2: begin
            if ($urandom_range(0, 7) == 0) rsp_stall <= !rsp_stall;
         end
         default: rsp_stall <= stall_count[2];
      endcase
   end

   // Response checker and watchdog.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_angles.size() == 0) begin
               $error("response beat with nothing expected: yaw %0d pitch %0d",
                  rsp_yaw_offset, rsp_pitch_offset);
               errors++;
            end else begin
               angles_type e;
               e = expected_angles.pop_front();
               if (rsp_yaw_offset !== e.yaw) begin
                  $error("yaw_offset expected %0d actual %0d",
                     $signed(e.yaw), rsp_yaw_offset);
                  errors++;
               end
               if (rsp_pitch_offset !== e.pitch) begin
                  $error("pitch_offset expected %0d actual %0d",
                     $signed(e.pitch), rsp_pitch_offset);
                  errors++;
               end
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)
               || (!req_valid && expected_angles.size() == 0)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= 5000) begin
               $display("pixel_offset_to_view_angles_tb: done, errors");
               $finish;
            end
         end
      end
   end

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, longint unsigned value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= CSR_DATA_W'(value);
      @(posedge clock);
      case (idx)
         CSR_FRAME_WIDTH: width_reg = value & 64'h3FFF;
         CSR_FRAME_HEIGHT: height_reg = value & 64'h3FFF;
         CSR_K_HORIZONTAL: kh_reg = value & 64'h3FFFFFF;
         default: kv_reg = value & 64'h3FFFFFF;
      endcase
   endtask

   task automatic set_lens(longint unsigned w, longint unsigned h,
         longint unsigned kh, longint unsigned kv);
      write_reg(CSR_FRAME_WIDTH, w);
      write_reg(CSR_FRAME_HEIGHT, h);
      write_reg(CSR_K_HORIZONTAL, kh);
      write_reg(CSR_K_VERTICAL, kv);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   task automatic add_target(longint unsigned cx, longint unsigned cy,
         longint unsigned f);
      pending_targets.push_back('{cx: COORD_W'(cx), cy: COORD_W'(cy),
         focal: FOCAL_W'(f)});
   endtask

   // Mostly centers inside the frame, with some anywhere in the field range.
   task automatic add_random_targets(int count);
      longint unsigned cx, cy, f;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 3) == 0) begin
            cx = $urandom_range(0, 131071);
            cy = $urandom_range(0, 131071);
         end else begin
            cx = $urandom_range(0, (width_reg << 4) > 131071 ? 131071 : width_reg << 4);
            cy = $urandom_range(0, (height_reg << 4) > 131071 ? 131071 : height_reg << 4);
         end
         case ($urandom_range(0, 5))
            0: f = $urandom_range(0, 15);
            1: f = $urandom_range(0, 262143);
            default: f = $urandom_range(256, 40000);
         endcase
         add_target(cx, cy, f);
      end
   endtask

   task automatic drain();
      while (pending_targets.size() > 0 || req_valid || expected_angles.size() > 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      for (int i = 0; i < CORDIC_STAGES; i++) atan_q40[i] = arctan_pow2(i);
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset defaults: zero lens constants give zero angles.
      add_target(0, 0, 256);
      add_target(131071, 131071, 262143);
      add_random_targets(40);
      drain();

      // Directed corners on a typical lens.
      set_lens(1920, 1080, 150000, 85000);
      add_target(1920 * 8, 1080 * 8, 1000);
      add_target(0, 0, 1000);
      add_target(131071, 131071, 1000);
      add_target(0, 131071, 1);
      add_target(131071, 0, 262143);
      add_target(500, 17000, 0);
      add_target(1920 * 8 + 1, 1080 * 8 - 1, 262143);
      add_target(30000, 1, 1);
      add_random_targets(140);
      drain();

      set_lens(16383, 16383, 67108863, 67108863);
      add_target(0, 131071, 1);
      add_target(16383 * 8, 16383 * 8, 5);
      add_random_targets(140);
      drain();

      set_lens(1, 1, 1, 1);
      add_target(0, 131071, 1);
      add_target(8, 8, 1);
      add_random_targets(140);
      drain();

      // Zero frame size forces zero angles.
      set_lens(0, 0, $urandom_range(1, 67108863), $urandom_range(1, 67108863));
      add_random_targets(60);
      drain();

      set_lens(8192, 8192, $urandom_range(0, 67108863), $urandom_range(0, 2000000));
      add_random_targets(140);
      drain();

      for (int p = 0; p < 5; p++) begin
         set_lens($urandom_range(1, 16383), $urandom_range(1, 16383),
            $urandom_range(0, 3000000), $urandom_range(0, 67108863));
         add_random_targets(120);
         drain();
      end

      repeat (120) @(posedge clock);
      if (errors == 0) begin
         $display("pixel_offset_to_view_angles_tb: done, clean");
      end else begin
         $display("pixel_offset_to_view_angles_tb: done, errors");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/core/pva_pkg.sv
rtl/core/pva_front.sv
rtl/core/pva_fifo.sv
rtl/core/pva_angle.sv
rtl/core/pixel_offset_to_view_angles.sv
tb/sv/pixel_offset_to_view_angles_tb.sv
